FILE: sv/oss_pkg.sv
package oss_pkg;

  // Size of the value domain; values 0 .. DOMAIN_SIZE-1 may be members.
  localparam int DOMAIN_SIZE = 1024;

  // Fixed field widths of the request and result channels.
  localparam int KIND_W = 2;
  localparam int OPND_W = 11;
  localparam int ANS_W  = 11;

  // Widths derived from the domain size.
  localparam int ADDR_W = $clog2(DOMAIN_SIZE);
  localparam int NODE_W = $clog2(DOMAIN_SIZE + 1);
  localparam int MAX_MEMBERS = (DOMAIN_SIZE < (1 << OPND_W)) ? DOMAIN_SIZE : (1 << OPND_W);
  localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);

  // Largest power of two not above the domain size: first step of the descent.
  localparam int STEP_LOG = ((1 << $clog2(DOMAIN_SIZE)) == DOMAIN_SIZE) ?
                            $clog2(DOMAIN_SIZE) : $clog2(DOMAIN_SIZE) - 1;
  localparam int TOP_STEP = 1 << STEP_LOG;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_KTH    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the accepted request
    logic clr_step;    // zero one entry of both memories
    logic upd_begin;   // flip the presence bit, adjust the member count, read first node
    logic upd_step;    // write one tree node and read the next one
    logic pfx_begin;   // read the first node of a prefix sum
    logic pfx_step;    // accumulate one node and read the next one
    logic kth_begin;   // set up the descent
    logic kth_read;    // read the candidate node of the descent
    logic kth_decide;  // take or skip the candidate, halve the step
    logic load_out;    // move the finished answer into the output register
  } oss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              clr_last;
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic              opnd_zero;
    logic              kth_bad;
    logic              needs_change;
    logic              upd_last;
    logic              pfx_last;
    logic              step_last;
    logic              out_busy;
  } oss_sts_t;

endpackage

FILE: sv/oss_req_if.sv
interface oss_req_if import oss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [OPND_W-1:0] operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink (input valid, input kind, input operand, output ready);
endinterface

FILE: sv/oss_res_if.sv
interface oss_res_if import oss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ANS_W-1:0] answer;
  logic             invalid;

  modport source (output valid, output answer, output invalid, input ready);
  modport sink (input valid, input answer, input invalid, output ready);
endinterface

FILE: sv/oss_ram.sv
module oss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/oss_ctrl.sv
module oss_ctrl import oss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  oss_sts_t sts,
  output oss_cmd_t cmd
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DISP = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_UPD  = 4'd4;
  localparam logic [3:0] ST_PFX  = 4'd5;
  localparam logic [3:0] ST_KRD  = 4'd6;
  localparam logic [3:0] ST_KDC  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        case (sts.kind)
          KIND_INSERT, KIND_DELETE: begin
            if (sts.in_range) begin
              state_next = ST_CHK;
            end else begin
              state_next = ST_IDLE;
            end
          end
          KIND_COUNT: begin
            if (sts.in_range && !sts.opnd_zero) begin
              cmd.pfx_begin = 1'b1;
              state_next    = ST_PFX;
            end else begin
              state_next = ST_FIN;
            end
          end
          default: begin
            if (sts.kth_bad) begin
              state_next = ST_FIN;
            end else begin
              cmd.kth_begin = 1'b1;
              state_next    = ST_KRD;
            end
          end
        endcase
      end
      ST_CHK: begin
        if (sts.needs_change) begin
          cmd.upd_begin = 1'b1;
          state_next    = ST_UPD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_UPD: begin
        cmd.upd_step = 1'b1;
        if (sts.upd_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_PFX: begin
        cmd.pfx_step = 1'b1;
        if (sts.pfx_last) begin
          state_next = ST_FIN;
        end
      end
      ST_KRD: begin
        cmd.kth_read = 1'b1;
        state_next   = ST_KDC;
      end
      ST_KDC: begin
        cmd.kth_decide = 1'b1;
        state_next     = sts.step_last ? ST_FIN : ST_KRD;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR;
      end
    endcase
  end

endmodule

FILE: sv/oss_dp.sv
module oss_dp import oss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  oss_cmd_t          cmd,
  output oss_sts_t          sts,
  input  logic [KIND_W-1:0] kind,
  input  logic [OPND_W-1:0] operand,
  input  logic              res_ready,
  output logic              res_valid,
  output logic [ANS_W-1:0]  answer,
  output logic              invalid
);

  // Latched request.
  logic [KIND_W-1:0] kind_q;
  logic [OPND_W-1:0] opnd_q;

  // Control state.
  logic [ADDR_W-1:0] clr_cnt;
  logic [CNT_W-1:0]  member_count;

  // Walk registers.
  logic [NODE_W-1:0] node;
  logic [CNT_W-1:0]  total;
  logic [NODE_W-1:0] pos;
  logic [NODE_W-1:0] step;
  logic [CNT_W-1:0]  left;
  logic              skip;

  // Memory ports.
  logic              pres_we;
  logic [ADDR_W-1:0] pres_waddr;
  logic              pres_wdata;
  logic              pres_rdata;
  logic              tree_we;
  logic [ADDR_W-1:0] tree_waddr;
  logic [CNT_W-1:0]  tree_wdata;
  logic [ADDR_W-1:0] tree_raddr;
  logic [CNT_W-1:0]  tree_rdata;

  // Derived values.
  logic              in_range;
  logic              is_insert;
  logic              kth_bad;
  logic [NODE_W-1:0] opnd_node;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W:0]   upd_next;
  logic [NODE_W-1:0] pfx_next;
  logic [NODE_W:0]   cand;

  assign in_range   = 32'(opnd_q) < DOMAIN_SIZE;
  assign is_insert  = (kind_q == KIND_INSERT);
  assign kth_bad    = (opnd_q == '0) || (32'(opnd_q) > 32'(member_count));
  assign opnd_node  = NODE_W'(opnd_q);
  assign first_node = opnd_node + NODE_W'(1);
  // Update walk climbs by the lowest set bit; prefix walk clears it.
  assign upd_next   = {1'b0, node} + {1'b0, node & (~node + NODE_W'(1))};
  assign pfx_next   = node & (node - NODE_W'(1));
  assign cand       = {1'b0, pos} + {1'b0, step};

  oss_ram #(.WIDTH(1), .DEPTH(DOMAIN_SIZE)) u_pres (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (pres_wdata),
    .raddr (ADDR_W'(opnd_q)),
    .rdata (pres_rdata)
  );

  oss_ram #(.WIDTH(CNT_W), .DEPTH(DOMAIN_SIZE)) u_tree (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  always_comb begin
    pres_we    = cmd.clr_step || cmd.upd_begin;
    pres_waddr = cmd.clr_step ? clr_cnt : ADDR_W'(opnd_q);
    pres_wdata = cmd.clr_step ? 1'b0 : is_insert;

    tree_we    = cmd.clr_step || cmd.upd_step;
    tree_waddr = cmd.clr_step ? clr_cnt : ADDR_W'(node - NODE_W'(1));
    if (cmd.clr_step) begin
      tree_wdata = '0;
    end else if (is_insert) begin
      tree_wdata = tree_rdata + CNT_W'(1);
    end else begin
      tree_wdata = tree_rdata - CNT_W'(1);
    end

    if (cmd.upd_begin) begin
      tree_raddr = ADDR_W'(first_node - NODE_W'(1));
    end else if (cmd.upd_step) begin
      tree_raddr = ADDR_W'(upd_next - (NODE_W + 1)'(1));
    end else if (cmd.pfx_begin) begin
      tree_raddr = ADDR_W'(opnd_node - NODE_W'(1));
    end else if (cmd.pfx_step) begin
      tree_raddr = ADDR_W'(node - NODE_W'(1));
    end else begin
      tree_raddr = ADDR_W'(cand - (NODE_W + 1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      member_count <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.upd_begin) begin
        member_count <= is_insert ? member_count + CNT_W'(1) : member_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q <= kind;
      opnd_q <= operand;
      total  <= '0;
    end
    if (cmd.upd_begin) begin
      node <= first_node;
    end else if (cmd.upd_step) begin
      node <= NODE_W'(upd_next);
    end else if (cmd.pfx_begin) begin
      node <= opnd_node & (opnd_node - NODE_W'(1));
    end else if (cmd.pfx_step) begin
      node <= pfx_next;
    end
    if (cmd.pfx_step) begin
      total <= total + tree_rdata;
    end
    if (cmd.kth_begin) begin
      pos  <= '0;
      step <= NODE_W'(TOP_STEP);
      left <= CNT_W'(opnd_q);
    end
    if (cmd.kth_read) begin
      skip <= cand > (NODE_W + 1)'(DOMAIN_SIZE);
    end
    if (cmd.kth_decide) begin
      if (!skip && (tree_rdata < left)) begin
        pos  <= NODE_W'(cand);
        left <= left - tree_rdata;
      end
      step <= step >> 1;
    end
  end

  // Output register: a finished answer waits here while the next request runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (kind_q == KIND_COUNT) begin
        answer  <= in_range ? ANS_W'(total) : ANS_W'(member_count);
        invalid <= 1'b0;
      end else if (kth_bad) begin
        answer  <= '0;
        invalid <= 1'b1;
      end else begin
        answer  <= ANS_W'(pos);
        invalid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.clr_last     = (clr_cnt == ADDR_W'(DOMAIN_SIZE - 1));
    sts.kind         = kind_q;
    sts.in_range     = in_range;
    sts.opnd_zero    = (opnd_q == '0);
    sts.kth_bad      = kth_bad;
    sts.needs_change = is_insert ? !pres_rdata : pres_rdata;
    sts.upd_last     = upd_next > (NODE_W + 1)'(DOMAIN_SIZE);
    sts.pfx_last     = (node == '0);
    sts.step_last    = (step == NODE_W'(1));
    sts.out_busy     = res_valid && !res_ready;
  end

endmodule

FILE: sv/order_statistic_set.sv
// Order statistic set over the values 0 .. DOMAIN_SIZE-1, kept as a presence
// bitmap and a Fenwick tree of counts, each in a RAM with registered read.
// Requests arrive on req (kind, operand) and are taken when valid and ready are
// both high. Insert and delete give no result; count and kth each give one
// result on res (answer, invalid), held in an output register.
// One request is worked on at a time. The tree RAM port sets the pace: an
// insert or delete that changes the set updates one tree node a cycle, a count
// sums the nodes of its prefix, and a kth query descends the tree, where each
// step of the descent reads a node and then decides on it. Ignored updates
// and out-of-range queries skip the tree walk.
// After reset both memories are cleared one entry a cycle, and req.ready
// stays low meanwhile.
// A request is accepted while an earlier result waits in the output register;
// if the receiver stalls, the next result waits in the datapath until the
// register is free, and no further request is accepted until then.
module order_statistic_set import oss_pkg::*; (
  input logic      clk,
  input logic      rst,
  oss_req_if.sink  req,
  oss_res_if.source res
);

  oss_cmd_t cmd;
  oss_sts_t sts;
  logic     ready;

  // The controller sequences the walks; the datapath owns the memories.
  oss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign req.ready = ready;

  oss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (req.kind),
    .operand   (req.operand),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .answer    (res.answer),
    .invalid   (res.invalid)
  );

endmodule
